>>> sv/tcrp_pkg.sv
`default_nettype none

package tcrp_pkg;

  // One byte of CSV text with its end-of-stream mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } text_item_t;

  // One result of the parser.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] order_id;
    logic [63:0] price_fixed;
    logic [63:0] quantity_fixed;
    logic [63:0] trade_time;
    logic        is_sell;
    logic [2:0]  error_code;
    logic [63:0] record_count;
    logic        is_last;
  } result_item_t;

  // Result kinds.
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_COMMA      = 3'd1;
  localparam logic [2:0] ERR_SIDE       = 3'd2;
  localparam logic [2:0] ERR_NEWLINE    = 3'd3;
  localparam logic [2:0] ERR_EOS_AT_SIDE = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  // Parser phases, one-hot.
  typedef enum logic [12:0] {
    PH_LINE  = 13'b0000000000001,
    PH_ID    = 13'b0000000000010,
    PH_PINT  = 13'b0000000000100,
    PH_PFRAC = 13'b0000000001000,
    PH_QINT  = 13'b0000000010000,
    PH_QFRAC = 13'b0000000100000,
    PH_SKIP  = 13'b0000001000000,
    PH_TIME  = 13'b0000010000000,
    PH_SIDE1 = 13'b0000100000000,
    PH_SIDEN = 13'b0001000000000,
    PH_TAIL  = 13'b0010000000000,
    PH_CR    = 13'b0100000000000,
    PH_ERR   = 13'b1000000000000
  } phase_t;

  // Powers of ten up to 10^18.
  function automatic logic [63:0] pow10(input logic [4:0] idx);
    logic [63:0] val;
    case (idx)
      5'd0:    val = 64'd1;
      5'd1:    val = 64'd10;
      5'd2:    val = 64'd100;
      5'd3:    val = 64'd1000;
      5'd4:    val = 64'd10000;
      5'd5:    val = 64'd100000;
      5'd6:    val = 64'd1000000;
      5'd7:    val = 64'd10000000;
      5'd8:    val = 64'd100000000;
      5'd9:    val = 64'd1000000000;
      5'd10:   val = 64'd10000000000;
      5'd11:   val = 64'd100000000000;
      5'd12:   val = 64'd1000000000000;
      5'd13:   val = 64'd10000000000000;
      5'd14:   val = 64'd100000000000000;
      5'd15:   val = 64'd1000000000000000;
      5'd16:   val = 64'd10000000000000000;
      5'd17:   val = 64'd100000000000000000;
      5'd18:   val = 64'd1000000000000000000;
      default: val = 64'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> sv/trade_csv_record_parser_core.sv
`default_nettype none

// Trade CSV record parser.
// The text channel (text_valid, text_stall, text_item) carries one CSV byte per
// transaction, with end_of_stream set on the last byte of a file. The result
// channel (result_valid, result_stall, result_item) carries records, parse errors
// and the end-of-stream summary, one per transaction; is_last marks the final
// result caused by a byte.
// Each accepted byte updates the row state in the same cycle and its results
// enter a four-entry result queue, whose head drives result_item. A byte is
// accepted every cycle while the receiver keeps up; the queue is the only
// thing that throttles input.
// An end-of-stream byte can cause two results; both enter the queue together.
// When the receiver stalls, results wait in the queue, and text_stall rises once
// fewer than two queue entries are free.
// Synchronous reset empties the queue and returns the parser to line start with
// all accumulators and the record count at zero.
// FRACTION_DIGITS sets the fixed-point scale of price and quantity (0 to 18).
module trade_csv_record_parser_core #(
  parameter int FRACTION_DIGITS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          text_valid,
  output logic                         text_stall,
  input  wire  tcrp_pkg::text_item_t   text_item,
  output logic                         result_valid,
  input  wire                          result_stall,
  output tcrp_pkg::result_item_t       result_item
);
  import tcrp_pkg::*;

  localparam logic [4:0] SCALE =
      5'((FRACTION_DIGITS > 18) ? 18 : ((FRACTION_DIGITS < 0) ? 0 : FRACTION_DIGITS));
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // Row state.
  phase_t      phase;
  phase_t      phase_next;
  logic [63:0] id_acc;
  logic [63:0] id_acc_next;
  logic [63:0] price_acc;
  logic [63:0] price_acc_next;
  logic [4:0]  price_cnt;
  logic [4:0]  price_cnt_next;
  logic [63:0] qty_acc;
  logic [63:0] qty_acc_next;
  logic [4:0]  qty_cnt;
  logic [4:0]  qty_cnt_next;
  logic [63:0] time_acc;
  logic [63:0] time_acc_next;
  logic        side_flag;
  logic        side_flag_next;
  logic [63:0] records;
  logic [63:0] records_next;

  // Result queue.
  result_item_t queue [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic [QAW:0]   count;

  logic [7:0]  b;
  logic        eos;
  logic        dig;
  logic [3:0]  d;
  logic        lineend;
  logic        accept;
  logic        pop;
  phase_t      phase_cur;
  phase_t      phase_mid;
  logic        ev_valid;
  logic        ev_record;
  logic [2:0]  ev_err;
  logic        clear_all;
  logic [1:0]  push_n;
  logic [63:0] price_step;
  logic [63:0] qty_step;
  result_item_t row_item;
  result_item_t sum_item;
  result_item_t slot0;
  result_item_t slot1;

  assign b       = text_item.data_byte;
  assign eos     = text_item.end_of_stream;
  assign dig     = (b >= CH_ZERO) && (b <= CH_NINE);
  assign d       = dig ? 4'(b - CH_ZERO) : 4'd0;
  assign lineend = (b == CH_LF) || (b == CH_CR);
  assign accept  = text_valid && !text_stall;
  assign pop     = result_valid && !result_stall;

  assign text_stall   = count > (QAW+1)'(QDEPTH - 2);
  assign result_valid = count != '0;
  assign result_item  = queue[head];

  // Fraction digit contributions, scaled by the digit's position.
  assign price_step = (price_cnt < SCALE) ? 64'(d * pow10(SCALE - 5'd1 - price_cnt)) : 64'd0;
  assign qty_step   = (qty_cnt < SCALE) ? 64'(d * pow10(SCALE - 5'd1 - qty_cnt)) : 64'd0;

  // Per-byte parse step: field transitions and accumulator updates.
  always_comb begin
    phase_cur      = ((phase == PH_LINE) && !lineend) ? PH_ID : phase;
    phase_mid      = phase_cur;
    id_acc_next    = id_acc;
    price_acc_next = price_acc;
    price_cnt_next = price_cnt;
    qty_acc_next   = qty_acc;
    qty_cnt_next   = qty_cnt;
    time_acc_next  = time_acc;
    side_flag_next = side_flag;
    ev_valid       = 1'b0;
    ev_record      = 1'b0;
    ev_err         = ERR_NONE;

    unique case (phase_cur)
      PH_ID: begin
        if (dig) begin
          id_acc_next = (id_acc << 3) + (id_acc << 1) + 64'(d);
        end else if (b == CH_COMMA) begin
          phase_mid = PH_PINT;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_PINT: begin
        if (dig) begin
          price_acc_next = (price_acc << 3) + (price_acc << 1) + 64'(d * pow10(SCALE));
        end else if (b == CH_DOT) begin
          phase_mid = PH_PFRAC;
        end else if (b == CH_COMMA) begin
          phase_mid = PH_QINT;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_PFRAC: begin
        if (dig) begin
          price_acc_next = price_acc + price_step;
          if (price_cnt < SCALE) begin
            price_cnt_next = price_cnt + 5'd1;
          end
        end else if (b == CH_COMMA) begin
          phase_mid = PH_QINT;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_QINT: begin
        if (dig) begin
          qty_acc_next = (qty_acc << 3) + (qty_acc << 1) + 64'(d * pow10(SCALE));
        end else if (b == CH_DOT) begin
          phase_mid = PH_QFRAC;
        end else if (b == CH_COMMA) begin
          phase_mid = PH_SKIP;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_QFRAC: begin
        if (dig) begin
          qty_acc_next = qty_acc + qty_step;
          if (qty_cnt < SCALE) begin
            qty_cnt_next = qty_cnt + 5'd1;
          end
        end else if (b == CH_COMMA) begin
          phase_mid = PH_SKIP;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_SKIP: begin
        if (b == CH_COMMA) begin
          phase_mid = PH_TIME;
        end else if (lineend) begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_TIME: begin
        if (dig) begin
          time_acc_next = (time_acc << 3) + (time_acc << 1) + 64'(d);
        end else if (b == CH_COMMA) begin
          phase_mid = PH_SIDE1;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_SIDE1: begin
        if ((b == CH_T_LO) || (b == CH_T_UP) || (b == CH_ONE)) begin
          side_flag_next = 1'b1;
          phase_mid      = PH_SIDEN;
        end else if ((b == CH_F_LO) || (b == CH_F_UP) || (b == CH_ZERO)) begin
          side_flag_next = 1'b0;
          phase_mid      = PH_SIDEN;
        end else begin
          ev_valid = 1'b1;
          ev_err   = ERR_SIDE;
        end
      end
      PH_SIDEN: begin
        if (b == CH_COMMA) begin
          phase_mid = PH_TAIL;
        end else if (lineend) begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      end
      PH_TAIL: begin
        if (b == CH_LF) begin
          ev_valid  = 1'b1;
          ev_record = 1'b1;
        end else if (b == CH_CR) begin
          phase_mid = PH_CR;
        end else if (b == CH_COMMA) begin
          ev_valid = 1'b1;
          ev_err   = ERR_NEWLINE;
        end
      end
      PH_CR: begin
        ev_valid = 1'b1;
        if (b == CH_LF) begin
          ev_record = 1'b1;
        end else begin
          ev_err = ERR_NEWLINE;
        end
      end
      default: begin
      end
    endcase

    // End of stream closes whatever row is open, unless this byte already did.
    if (eos && !ev_valid) begin
      unique case (phase_mid)
        PH_LINE, PH_ERR: begin
        end
        PH_TAIL, PH_CR: begin
          ev_valid  = 1'b1;
          ev_record = 1'b1;
        end
        PH_SIDE1: begin
          ev_valid = 1'b1;
          ev_err   = ERR_EOS_AT_SIDE;
        end
        default: begin
          ev_valid = 1'b1;
          ev_err   = ERR_COMMA;
        end
      endcase
    end

    if (ev_valid) begin
      phase_next = ev_record ? PH_LINE : PH_ERR;
    end else begin
      phase_next = phase_mid;
    end
    records_next = records + (ev_record ? 64'd1 : 64'd0);
    clear_all    = eos;
  end

  // Result items: row fields as they stood before this byte, count including it.
  always_comb begin
    row_item                = '0;
    row_item.kind           = ev_record ? KIND_RECORD : KIND_ERROR;
    row_item.error_code     = ev_record ? ERR_NONE : ev_err;
    row_item.record_count   = records_next;
    row_item.is_last        = !eos;
    if (ev_record) begin
      row_item.order_id       = id_acc;
      row_item.price_fixed    = price_acc;
      row_item.quantity_fixed = qty_acc;
      row_item.trade_time     = time_acc;
      row_item.is_sell        = side_flag;
    end

    sum_item              = '0;
    sum_item.kind         = KIND_SUMMARY;
    sum_item.error_code   = ERR_NONE;
    sum_item.record_count = records_next;
    sum_item.is_last      = 1'b1;

    slot0  = ev_valid ? row_item : sum_item;
    slot1  = sum_item;
    push_n = 2'(ev_valid) + 2'(eos);
  end

  // Row state registers.
  always_ff @(posedge clk) begin
    if (rst || (accept && clear_all)) begin
      phase     <= PH_LINE;
      id_acc    <= '0;
      price_acc <= '0;
      price_cnt <= '0;
      qty_acc   <= '0;
      qty_cnt   <= '0;
      time_acc  <= '0;
      side_flag <= 1'b0;
      records   <= '0;
    end else if (accept) begin
      if (phase_next == PH_LINE) begin
        id_acc    <= '0;
        price_acc <= '0;
        price_cnt <= '0;
        qty_acc   <= '0;
        qty_cnt   <= '0;
        time_acc  <= '0;
        side_flag <= 1'b0;
      end else begin
        id_acc    <= id_acc_next;
        price_acc <= price_acc_next;
        price_cnt <= price_cnt_next;
        qty_acc   <= qty_acc_next;
        qty_cnt   <= qty_cnt_next;
        time_acc  <= time_acc_next;
        side_flag <= side_flag_next;
      end
      phase   <= phase_next;
      records <= records_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && (push_n != 2'd0)) begin
      queue[tail] <= slot0;
      if (push_n == 2'd2) begin
        queue[tail + QAW'(1)] <= slot1;
      end
    end
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + QAW'(1);
      end
      if (accept) begin
        tail <= tail + QAW'(push_n);
      end
      count <= count + (accept ? (QAW+1)'(push_n) : '0) - (QAW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> bench/csv_check_pkg.sv
package csv_check_pkg;
  import tcrp_pkg::*;

  // Fixed-point scale used by both the parser instance and the predictor.
  localparam int PRICE_SCALE_DIGITS = 8;
  localparam int SCALE_IDX = (PRICE_SCALE_DIGITS > 18) ? 18 : PRICE_SCALE_DIGITS;

  class csv_row_scoreboard;
    // Predicted parser state.
    phase_t      phase;
    logic [63:0] id_acc;
    logic [63:0] price_acc;
    logic [63:0] qty_acc;
    logic [63:0] time_acc;
    logic [63:0] records;
    logic [4:0]  price_frac;
    logic [4:0]  qty_frac;
    logic        sell_side;

    // Results caused by the byte being processed, and all results still owed.
    result_item_t step_q[$];
    result_item_t pending_q[$];

    int unsigned mismatches;
    int unsigned live_bytes;

    function new();
      mismatches  = 0;
      live_bytes  = 0;
      restart();
    endfunction

    function void clear_row();
      id_acc     = '0;
      price_acc  = '0;
      price_frac = '0;
      qty_acc    = '0;
      qty_frac   = '0;
      time_acc   = '0;
      sell_side  = 1'b0;
    endfunction

    function void restart();
      clear_row();
      records = '0;
      phase   = PH_LINE;
    endfunction

    static function logic [63:0] ten_pow(int unsigned n);
      logic [63:0] v;
      v = 64'd1;
      for (int unsigned i = 0; i < n; i++) v = v * 64'd10;
      return v;
    endfunction

    // Integer digit of a scaled decimal: shift left one decimal place.
    static function logic [63:0] scaled_int(logic [63:0] acc, logic [63:0] d);
      return acc * 64'd10 + d * ten_pow(SCALE_IDX);
    endfunction

    // Fraction digit: weighted by its position, dropped once the scale is full.
    static function void scaled_frac(ref logic [63:0] acc, ref logic [4:0] cnt,
                                     input logic [63:0] d);
      if (cnt < SCALE_IDX) begin
        acc = acc + d * ten_pow(SCALE_IDX - 1 - cnt);
        cnt = cnt + 5'd1;
      end
    endfunction

    function void add(logic [1:0] kind, logic [2:0] code, bit with_row);
      result_item_t r;
      r = '0;
      r.kind         = kind;
      r.error_code   = code;
      r.record_count = records;
      if (with_row) begin
        r.order_id       = id_acc;
        r.price_fixed    = price_acc;
        r.quantity_fixed = qty_acc;
        r.trade_time     = time_acc;
        r.is_sell        = sell_side;
      end
      step_q.push_back(r);
    endfunction

    function void add_record();
      records = records + 64'd1;
      add(KIND_RECORD, ERR_NONE, 1'b1);
      clear_row();
      phase = PH_LINE;
    endfunction

    function void add_error(logic [2:0] code);
      add(KIND_ERROR, code, 1'b0);
      phase = PH_ERR;
    endfunction

    // Advance the predicted parser by one accepted byte and queue its results.
    function void note_byte(text_item_t t);
      logic [7:0]  b;
      logic [63:0] d;
      bit          dig;
      bit          eol;
      b   = t.data_byte;
      dig = (b >= CH_ZERO) && (b <= CH_NINE);
      d   = dig ? (64'(b) - 64'(CH_ZERO)) : 64'd0;
      eol = (b == CH_LF) || (b == CH_CR);
      step_q.delete();

      if (phase != PH_ERR && !(phase == PH_LINE && eol)) live_bytes++;
      if (phase == PH_LINE && !eol) phase = PH_ID;

      case (phase)
        PH_ID: begin
          if (dig) id_acc = id_acc * 64'd10 + d;
          else if (b == CH_COMMA) phase = PH_PINT;
          else add_error(ERR_COMMA);
        end
        PH_PINT: begin
          if (dig) price_acc = scaled_int(price_acc, d);
          else if (b == CH_DOT) phase = PH_PFRAC;
          else if (b == CH_COMMA) phase = PH_QINT;
          else add_error(ERR_COMMA);
        end
        PH_PFRAC: begin
          if (dig) scaled_frac(price_acc, price_frac, d);
          else if (b == CH_COMMA) phase = PH_QINT;
          else add_error(ERR_COMMA);
        end
        PH_QINT: begin
          if (dig) qty_acc = scaled_int(qty_acc, d);
          else if (b == CH_DOT) phase = PH_QFRAC;
          else if (b == CH_COMMA) phase = PH_SKIP;
          else add_error(ERR_COMMA);
        end
        PH_QFRAC: begin
          if (dig) scaled_frac(qty_acc, qty_frac, d);
          else if (b == CH_COMMA) phase = PH_SKIP;
          else add_error(ERR_COMMA);
        end
        PH_SKIP: begin
          if (b == CH_COMMA) phase = PH_TIME;
          else if (eol) add_error(ERR_COMMA);
        end
        PH_TIME: begin
          if (dig) time_acc = time_acc * 64'd10 + d;
          else if (b == CH_COMMA) phase = PH_SIDE1;
          else add_error(ERR_COMMA);
        end
        PH_SIDE1: begin
          if (b == CH_T_LO || b == CH_T_UP || b == CH_ONE) begin
            sell_side = 1'b1;
            phase     = PH_SIDEN;
          end else if (b == CH_F_LO || b == CH_F_UP || b == CH_ZERO) begin
            sell_side = 1'b0;
            phase     = PH_SIDEN;
          end else begin
            add_error(ERR_SIDE);
          end
        end
        PH_SIDEN: begin
          if (b == CH_COMMA) phase = PH_TAIL;
          else if (eol) add_error(ERR_COMMA);
        end
        PH_TAIL: begin
          if (b == CH_LF) add_record();
          else if (b == CH_CR) phase = PH_CR;
          else if (b == CH_COMMA) add_error(ERR_NEWLINE);
        end
        PH_CR: begin
          if (b == CH_LF) add_record();
          else add_error(ERR_NEWLINE);
        end
        default: ;
      endcase

      // End of stream: close the open row, then report the count and start over.
      if (t.end_of_stream) begin
        case (phase)
          PH_LINE, PH_ERR: ;
          PH_TAIL, PH_CR:  add_record();
          PH_SIDE1:        add_error(ERR_EOS_AT_SIDE);
          default:         add_error(ERR_COMMA);
        endcase
        add(KIND_SUMMARY, ERR_NONE, 1'b0);
        restart();
      end

      if (step_q.size() > 0) step_q[step_q.size() - 1].is_last = 1'b1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Match one accepted result against the oldest expectation.
    function void check_result(result_item_t got);
      result_item_t want;
      if (pending_q.size() == 0) begin
        $error("kind: expected no result, actual %0d", got.kind);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      compare("kind",           64'(want.kind),       64'(got.kind));
      compare("order_id",       want.order_id,        got.order_id);
      compare("price_fixed",    want.price_fixed,     got.price_fixed);
      compare("quantity_fixed", want.quantity_fixed,  got.quantity_fixed);
      compare("trade_time",     want.trade_time,      got.trade_time);
      compare("is_sell",        64'(want.is_sell),    64'(got.is_sell));
      compare("error_code",     64'(want.error_code), 64'(got.error_code));
      compare("record_count",   want.record_count,    got.record_count);
      compare("is_last",        64'(want.is_last),    64'(got.is_last));
    endfunction
  endclass

endpackage

>>> bench/trade_csv_record_parser_core_tb.sv
module trade_csv_record_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrp_pkg::*;
  import csv_check_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         text_valid   = 1'b0;
  logic         text_stall;
  text_item_t   text_item    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  bit           tx_idle = 1'b0;
  bit           rx_idle = 1'b0;
  int unsigned  rx_wait = 0;
  int unsigned  quiet_cycles = 0;
  logic [7:0]   stream_q[$];

  csv_row_scoreboard sb = new();

  trade_csv_record_parser_core #(
    .FRACTION_DIGITS(PRICE_SCALE_DIGITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each transaction, then stall for a random time if rx_idle.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (result_valid && !result_stall) begin
        sb.check_result(result_item);
        rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      result_stall <= (rx_wait > 0);
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one byte, after a random gap when tx_idle is set, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    text_item_t  t;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    t.data_byte     = b;
    t.end_of_stream = eos;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= t;
    do @(posedge clk); while (text_stall);
    sb.note_byte(t);
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos_last && (i == s.len() - 1));
  endtask

  // Stop sending until every owed result has come back.
  task automatic hold_until_drained();
    text_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  // Mostly short digit runs, sometimes long enough to wrap 64 bits.
  function automatic int unsigned draw_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 4);
  endfunction

  function automatic void put_digits(int unsigned n);
    for (int unsigned i = 0; i < n; i++) stream_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // Any byte that cannot end a free-text field.
  function automatic void put_filler(int unsigned n);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA || b == CH_CR || b == CH_LF);
      stream_q.push_back(b);
    end
  endfunction

  function automatic void put_decimal();
    put_digits(draw_len());
    if ($urandom_range(0, 1)) begin
      stream_q.push_back(CH_DOT);
      put_digits(($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8));
    end
    stream_q.push_back(CH_COMMA);
  endfunction

  function automatic void put_row();
    logic [7:0] side_ch;
    case ($urandom_range(0, 5))
      0:       side_ch = CH_T_LO;
      1:       side_ch = CH_T_UP;
      2:       side_ch = CH_ONE;
      3:       side_ch = CH_F_LO;
      4:       side_ch = CH_F_UP;
      default: side_ch = CH_ZERO;
    endcase
    put_digits(draw_len());
    stream_q.push_back(CH_COMMA);
    put_decimal();
    put_decimal();
    put_filler($urandom_range(0, 4));
    stream_q.push_back(CH_COMMA);
    put_digits(draw_len());
    stream_q.push_back(CH_COMMA);
    stream_q.push_back(side_ch);
    put_filler($urandom_range(0, 3));
    stream_q.push_back(CH_COMMA);
    put_filler($urandom_range(0, 3));
  endfunction

  // Build one stream of well-formed rows, now and then damaged, and send it.
  task automatic run_stream();
    int unsigned rows;
    int unsigned pos;
    int unsigned cut;
    int unsigned ending;
    bit          damaged;
    stream_q.delete();
    rows    = $urandom_range(1, 4);
    damaged = 1'b0;
    for (int unsigned r = 0; r < rows && !damaged; r++) begin
      if ($urandom_range(0, 4) == 0) stream_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      pos = stream_q.size();
      put_row();
      // Last row may end without a line end, or on a bare CR.
      ending = (r == rows - 1) ? $urandom_range(0, 3) : $urandom_range(1, 2);
      if (ending == 1) stream_q.push_back(CH_LF);
      if (ending >= 2) stream_q.push_back(CH_CR);
      if (ending == 2) stream_q.push_back(CH_LF);

      if ($urandom_range(0, 5) == 0) begin
        damaged = 1'b1;
        case ($urandom_range(0, 4))
          0: stream_q[$urandom_range(pos, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            cut = $urandom_range(pos, stream_q.size() - 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
          end
          2: stream_q.insert($urandom_range(pos, stream_q.size()), 8'($urandom_range(0, 255)));
          3: stream_q.insert($urandom_range(pos, stream_q.size()), CH_COMMA);
          default: stream_q.insert($urandom_range(pos, stream_q.size()),
                                   $urandom_range(0, 1) ? CH_CR : CH_LF);
        endcase
        repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (stream_q.size() == 0) stream_q.push_back(8'($urandom_range(0, 255)));
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Blank line ends at line start are skipped.
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    // Row with every field empty but the side flag T, closed by CR LF.
    send_text(",,,,,T,", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    // Stream ends where the side flag should start.
    send_text(",,,,,", 1'b1);
    // Top byte value as a bad first byte, ending the stream at once.
    send_byte(8'hFF, 1'b1);
    // Stream holding only a line end: summary alone.
    send_byte(CH_LF, 1'b1);
    // Stream ends in the last field: record and summary from one byte.
    send_text(",,,,,f,", 1'b1);
    hold_until_drained();

    // Random streams, with idle patterns chosen per stream.
    while (sb.live_bytes < 900) begin
      {tx_idle, rx_idle} = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      run_stream();
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> trade_csv_record_parser_core.f
sv/tcrp_pkg.sv
sv/trade_csv_record_parser_core.sv
bench/csv_check_pkg.sv
bench/trade_csv_record_parser_core_tb.sv
